// ===== src/cswt_pkg.sv =====
// ----------------------------------------------------------------------------
// Clock and stopwatch ticker package
// Shared widths, register indexes, sequencer states and unit status type.
// ----------------------------------------------------------------------------
package cswt_pkg;

	localparam int TICK_W = 10;
	localparam int STEP_CNT_W = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTI_TICKS = 2'd2;

	localparam logic [TICK_W-1:0] RST_TICKS_PER_SECOND = 10'd500;
	localparam logic [TICK_W-1:0] RST_BLINK_PERIOD = 10'd250;
	localparam logic [TICK_W-1:0] RST_CENTI_TICKS = 10'd5;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_BLINK = 4'b0010,
		S_CENTI = 4'b0100,
		S_WB    = 4'b1000
	} seq_state_t;

	typedef struct packed {
		logic done;
		logic zero;
	} mod_status_t;

endpackage

// ===== src/cswt_mod_unit.sv =====
// ----------------------------------------------------------------------------
// Iterative remainder unit
// Restoring division, one quotient bit per cycle; reports whether the
// remainder of the dividend by the divisor is zero.
// ----------------------------------------------------------------------------
module cswt_mod_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cswt_pkg::TICK_W-1:0] dividend,
	input  logic [cswt_pkg::TICK_W-1:0] divisor,
	output cswt_pkg::mod_status_t       status
);
	import cswt_pkg::*;

	logic [TICK_W-1:0]     rem_q;
	logic [TICK_W-1:0]     dvd_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic [TICK_W:0]       trial;
	logic [TICK_W:0]       rem_next;
	logic                  fits;

	assign trial = {rem_q, dvd_q[TICK_W-1]};
	assign fits = trial >= {1'b0, divisor};
	assign rem_next = fits ? (trial - {1'b0, divisor}) : trial;

	assign status.done = (cnt_q == STEP_CNT_W'(1));
	assign status.zero = (rem_next == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= STEP_CNT_W'(TICK_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - STEP_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= rem_next[TICK_W-1:0];
			dvd_q <= {dvd_q[TICK_W-2:0], 1'b0};
		end
	end

endmodule

// ===== src/clock_and_stopwatch_ticker.sv =====
// ----------------------------------------------------------------------------
// Clock and stopwatch ticker
// Counts ticks into a 24-hour clock, a blink phase and a stopwatch.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake           | Word
// in      | input     | in_valid/in_ready   | run_stopwatch
// out     | output    | out_valid/out_ready | clock, display, blink, stopwatch
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Ticks are worked one at a time: the accepting cycle counts the tick, the
// shared remainder unit tests the blink period and then the centisecond
// divisor, and a write-back state commits. The result word is loaded at
// write-back, and the next word can be taken in the cycle after that.
// Reset restores the register defaults and clears all counters at once.
// A stalled result is held in the output register while the next tick is
// already being worked on; write-back waits until that register is free.
// ----------------------------------------------------------------------------
module clock_and_stopwatch_ticker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           run_stopwatch,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [4:0]                     clock_hours,
	output logic [5:0]                     clock_minutes,
	output logic [5:0]                     clock_seconds,
	output logic [12:0]                    display_value,
	output logic                           display_update,
	output logic                           blink_phase,
	output logic                           refresh,
	output logic [6:0]                     watch_centis,
	output logic [5:0]                     watch_seconds,
	output logic [5:0]                     watch_minutes,
	output logic [6:0]                     watch_hours,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cswt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cswt_pkg::TICK_W-1:0]    cfg_data
);
	import cswt_pkg::*;

	seq_state_t        state_q;
	logic [TICK_W-1:0] tps_q, blink_q, centi_q, tick_q;
	logic [5:0]        secs_q, mins_q, sw_secs_q, sw_mins_q;
	logic [4:0]        hours_q;
	logic [6:0]        centis_q, sw_hours_q;
	logic              phase_q, upd_q, run_q, blink_hit_q, out_valid_q;

	logic [TICK_W:0]   tick_inc;
	logic              tick_wrap, accept, commit, mod_start, watch_adv;
	logic [TICK_W-1:0] tick_new, mod_dividend, mod_divisor;
	logic [5:0]        secs_n, mins_n, sw_secs_n, sw_mins_n;
	logic [4:0]        hours_n;
	logic [6:0]        centis_n, sw_hours_n;
	logic              phase_n, centi_hit;
	mod_status_t       mod_st;

	assign in_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept = in_valid && in_ready;
	assign commit = (state_q == S_WB) && (!out_valid_q || out_ready);

	assign tick_inc = {1'b0, tick_q} + (TICK_W+1)'(1);
	assign tick_wrap = tick_inc >= {1'b0, tps_q};
	assign tick_new = tick_wrap ? '0 : tick_inc[TICK_W-1:0];

	assign mod_start = accept || ((state_q == S_BLINK) && mod_st.done);
	assign mod_dividend = (state_q == S_IDLE) ? tick_new : tick_q;
	assign mod_divisor = (state_q == S_CENTI) ? centi_q : blink_q;
	assign centi_hit = mod_st.zero && (centi_q != '0);

	cswt_mod_unit u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_dividend),
		.divisor  (mod_divisor),
		.status   (mod_st)
	);

	always_comb begin
		secs_n = secs_q;
		mins_n = mins_q;
		hours_n = hours_q;
		if (tick_wrap) begin
			if (secs_q >= 6'd59) begin
				secs_n = '0;
				if (mins_q >= 6'd59) begin
					mins_n = '0;
					hours_n = (hours_q >= 5'd23) ? '0 : hours_q + 5'd1;
				end else begin
					mins_n = mins_q + 6'd1;
				end
			end else begin
				secs_n = secs_q + 6'd1;
			end
		end
	end

	always_comb begin
		watch_adv = run_q;
		phase_n = phase_q ^ blink_hit_q;
		centis_n = centis_q;
		sw_secs_n = sw_secs_q;
		sw_mins_n = sw_mins_q;
		sw_hours_n = sw_hours_q;
		if (watch_adv) begin
			if (centis_q >= 7'd99) begin
				centis_n = '0;
				if (sw_secs_q >= 6'd59) begin
					sw_secs_n = '0;
					if (sw_mins_q >= 6'd59) begin
						sw_mins_n = '0;
						sw_hours_n = (sw_hours_q >= 7'd99) ? '0 : sw_hours_q + 7'd1;
					end else begin
						sw_mins_n = sw_mins_q + 6'd1;
					end
				end else begin
					sw_secs_n = sw_secs_q + 6'd1;
				end
			end else begin
				centis_n = centis_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= RST_TICKS_PER_SECOND;
			blink_q <= RST_BLINK_PERIOD;
			centi_q <= RST_CENTI_TICKS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TICKS_PER_SECOND: tps_q <= cfg_data;
				REG_BLINK_PERIOD:     blink_q <= cfg_data;
				REG_CENTI_TICKS:      centi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tick_q <= '0;
			secs_q <= '0;
			mins_q <= '0;
			hours_q <= '0;
			phase_q <= 1'b0;
			centis_q <= '0;
			sw_secs_q <= '0;
			sw_mins_q <= '0;
			sw_hours_q <= '0;
			upd_q <= 1'b0;
			run_q <= 1'b0;
			blink_hit_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						tick_q <= tick_new;
						secs_q <= secs_n;
						mins_q <= mins_n;
						hours_q <= hours_n;
						upd_q <= tick_wrap;
						run_q <= run_stopwatch;
						state_q <= S_BLINK;
					end
				end
				S_BLINK: begin
					if (mod_st.done) begin
						blink_hit_q <= mod_st.zero && (blink_q != '0);
						state_q <= S_CENTI;
					end
				end
				S_CENTI: begin
					if (mod_st.done) begin
						run_q <= run_q && centi_hit;
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (commit) begin
						phase_q <= phase_n;
						centis_q <= centis_n;
						sw_secs_q <= sw_secs_n;
						sw_mins_q <= sw_mins_n;
						sw_hours_q <= sw_hours_n;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			clock_hours <= hours_q;
			clock_minutes <= mins_q;
			clock_seconds <= secs_q;
			display_value <= 13'({7'd0, mins_q} * 13'd100) + {7'd0, secs_q};
			display_update <= upd_q;
			blink_phase <= phase_n;
			refresh <= blink_hit_q || run_q;
			watch_centis <= centis_n;
			watch_seconds <= sw_secs_n;
			watch_minutes <= sw_mins_n;
			watch_hours <= sw_hours_n;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/clock_and_stopwatch_ticker_checker.sv =====
// ----------------------------------------------------------------------------
// Clock and stopwatch ticker checker
// Port-level properties of the ticker, bound to the top level.
// ----------------------------------------------------------------------------
module clock_and_stopwatch_ticker_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [4:0]  clock_hours,
	input logic [5:0]  clock_minutes,
	input logic [5:0]  clock_seconds,
	input logic [12:0] display_value,
	input logic [6:0]  watch_centis
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(display_value)
			&& $stable(watch_centis))
		else $error("stalled result word changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new word accepted while a tick is in progress");

	a_display_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> display_value == ({7'd0, clock_minutes} * 13'd100
			+ {7'd0, clock_seconds}))
		else $error("display value does not match clock");

	a_clock_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> clock_seconds < 6'd60 && clock_minutes < 6'd60
			&& clock_hours < 5'd24 && watch_centis < 7'd100)
		else $error("clock or stopwatch out of range");

endmodule

bind clock_and_stopwatch_ticker clock_and_stopwatch_ticker_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.clock_hours   (clock_hours),
	.clock_minutes (clock_minutes),
	.clock_seconds (clock_seconds),
	.display_value (display_value),
	.watch_centis  (watch_centis)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Clock and stopwatch ticker testbench
// Sends ticks with random stopwatch run flags under several period settings,
// predicts the clock, blink and stopwatch after every tick, and compares each
// result word field by field against the oldest predicted reading.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cswt_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int PHASES = 12;
	localparam int TICKS_PER_PHASE = 160;

	typedef struct packed {
		logic [4:0]  clock_hours;
		logic [5:0]  clock_minutes;
		logic [5:0]  clock_seconds;
		logic [12:0] display_value;
		logic        display_update;
		logic        blink_phase;
		logic        refresh;
		logic [6:0]  watch_centis;
		logic [5:0]  watch_seconds;
		logic [5:0]  watch_minutes;
		logic [6:0]  watch_hours;
	} reading_t;

	typedef int field_vals_t [11];

	class clock_tracker;
		logic [TICK_W-1:0] ticks_per_second;
		logic [TICK_W-1:0] blink_period;
		logic [TICK_W-1:0] centi_ticks;
		int tick_count, secs, mins, hours, phase;
		int centis, sw_secs, sw_mins, sw_hours;
		reading_t pending_readings[$];
		string field_names[11];
		int fails;

		function new();
			ticks_per_second = RST_TICKS_PER_SECOND;
			blink_period = RST_BLINK_PERIOD;
			centi_ticks = RST_CENTI_TICKS;
			tick_count = 0;
			secs = 0;
			mins = 0;
			hours = 0;
			phase = 0;
			centis = 0;
			sw_secs = 0;
			sw_mins = 0;
			sw_hours = 0;
			fails = 0;
			field_names = '{"clock_hours", "clock_minutes", "clock_seconds",
				"display_value", "display_update", "blink_phase", "refresh",
				"watch_centis", "watch_seconds", "watch_minutes", "watch_hours"};
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] data);
			case (idx)
				REG_TICKS_PER_SECOND: ticks_per_second = data;
				REG_BLINK_PERIOD: blink_period = data;
				REG_CENTI_TICKS: centi_ticks = data;
				default: ;
			endcase
		endfunction

		function bit hits_period(int count, logic [TICK_W-1:0] period);
			return period != 0 && (count % period) == 0;
		endfunction

		function void note_tick(logic run);
			reading_t r;
			bit upd;
			bit refr;
			upd = 1'b0;
			refr = 1'b0;
			tick_count++;
			if (tick_count >= ticks_per_second) begin
				tick_count = 0;
				upd = 1'b1;
				secs++;
				if (secs == 60) begin
					secs = 0;
					mins++;
					if (mins == 60) begin
						mins = 0;
						hours++;
						if (hours == 24)
							hours = 0;
					end
				end
			end
			if (hits_period(tick_count, blink_period)) begin
				phase ^= 1;
				refr = 1'b1;
			end
			if (run && hits_period(tick_count, centi_ticks)) begin
				refr = 1'b1;
				centis++;
				if (centis == 100) begin
					centis = 0;
					sw_secs++;
					if (sw_secs == 60) begin
						sw_secs = 0;
						sw_mins++;
						if (sw_mins == 60) begin
							sw_mins = 0;
							sw_hours++;
							if (sw_hours == 100)
								sw_hours = 0;
						end
					end
				end
			end
			r.clock_hours = 5'(hours);
			r.clock_minutes = 6'(mins);
			r.clock_seconds = 6'(secs);
			r.display_value = 13'(mins * 100 + secs);
			r.display_update = upd;
			r.blink_phase = 1'(phase);
			r.refresh = refr;
			r.watch_centis = 7'(centis);
			r.watch_seconds = 6'(sw_secs);
			r.watch_minutes = 6'(sw_mins);
			r.watch_hours = 7'(sw_hours);
			pending_readings.push_back(r);
		endfunction

		function field_vals_t split(reading_t r);
			field_vals_t v;
			v = '{int'(r.clock_hours), int'(r.clock_minutes), int'(r.clock_seconds),
				int'(r.display_value), int'(r.display_update), int'(r.blink_phase),
				int'(r.refresh), int'(r.watch_centis), int'(r.watch_seconds),
				int'(r.watch_minutes), int'(r.watch_hours)};
			return v;
		endfunction

		function void check_reading(reading_t got);
			reading_t want;
			field_vals_t w;
			field_vals_t g;
			if (pending_readings.size() == 0) begin
				$display("%0t: result word arrived with no tick pending", $time);
				fails++;
				return;
			end
			want = pending_readings.pop_front();
			w = split(want);
			g = split(got);
			for (int i = 0; i < 11; i++) begin
				if (w[i] != g[i]) begin
					$display("%0t: %s expected %0d actual %0d", $time, field_names[i],
						w[i], g[i]);
					fails++;
				end
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 run_stopwatch;
	logic                 out_valid;
	logic                 out_ready;
	logic [4:0]           clock_hours;
	logic [5:0]           clock_minutes;
	logic [5:0]           clock_seconds;
	logic [12:0]          display_value;
	logic                 display_update;
	logic                 blink_phase;
	logic                 refresh;
	logic [6:0]           watch_centis;
	logic [5:0]           watch_seconds;
	logic [5:0]           watch_minutes;
	logic [6:0]           watch_hours;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TICK_W-1:0]    cfg_data;

	clock_tracker tracker;
	reading_t seen_reading;
	int send_idle_pct = 31;
	int recv_idle_pct = 67;
	int cycle_count = 0;

	clock_and_stopwatch_ticker u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.run_stopwatch(run_stopwatch),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.clock_hours(clock_hours),
		.clock_minutes(clock_minutes),
		.clock_seconds(clock_seconds),
		.display_value(display_value),
		.display_update(display_update),
		.blink_phase(blink_phase),
		.refresh(refresh),
		.watch_centis(watch_centis),
		.watch_seconds(watch_seconds),
		.watch_minutes(watch_minutes),
		.watch_hours(watch_hours),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_reading = {clock_hours, clock_minutes, clock_seconds, display_value,
				display_update, blink_phase, refresh, watch_centis, watch_seconds,
				watch_minutes, watch_hours};
			tracker.check_reading(seen_reading);
		end
	end

	task automatic send_tick(input logic run);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		run_stopwatch = run;
		do @(posedge clk); while (!in_ready);
		tracker.note_tick(run);
		@(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [TICK_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_register(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (tracker.pending_readings.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_periods(input logic [TICK_W-1:0] tps, input logic [TICK_W-1:0] blink,
			input logic [TICK_W-1:0] centi);
		wait_drained();
		write_register(REG_TICKS_PER_SECOND, tps);
		write_register(REG_BLINK_PERIOD, blink);
		write_register(REG_CENTI_TICKS, centi);
		if ($urandom_range(0, 3) == 0)
			write_register(REG_UNUSED, TICK_W'($urandom_range(0, 1023)));
	endtask

	function automatic logic [TICK_W-1:0] pick_period();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4, 5, 6: return TICK_W'($urandom_range(1, 8));
			default: return TICK_W'($urandom_range(1, 1023));
		endcase
	endfunction

	initial begin
		tracker = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		run_stopwatch = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);

		set_periods(10'd3, 10'd2, 10'd1);
		write_register(REG_UNUSED, 10'h3FF);
		for (int i = 0; i < 6; i++)
			send_tick(i[0]);

		// Every tick wraps; blink and stopwatch stay put.
		set_periods(10'd0, 10'd0, 10'd0);
		repeat (4) send_tick(1'b1);

		set_periods(10'h3FF, 10'h3FF, 10'h3FF);
		repeat (6) send_tick(1'b1);

		// The count is now above the new limit, so the next tick wraps.
		wait_drained();
		write_register(REG_TICKS_PER_SECOND, 10'd2);
		send_tick(1'b1);
		send_tick(1'b0);
		set_periods(10'd2, 10'd1, 10'd1);
		send_tick(1'b1);
		send_tick(1'b1);

		for (int p = 0; p < PHASES; p++) begin
			if (p < PHASES / 3) begin
				send_idle_pct = 31;
				recv_idle_pct = 67;
			end else if (p < 2 * PHASES / 3) begin
				send_idle_pct = 67;
				recv_idle_pct = 31;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			set_periods(pick_period(), pick_period(), pick_period());
			for (int n = 0; n < TICKS_PER_PHASE; n++) begin
				if ($urandom_range(0, 149) == 0)
					wait_drained();
				send_tick(1'($urandom_range(0, 1)));
			end
		end

		wait_drained();
		repeat (30) @(negedge clk);
		if (tracker.fails == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
